[hw/rtl/tsps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solver package
// Shared types, command codes and register indexes for the line solver.
// ----------------------------------------------------------------------------
package tsps_pkg;

    localparam int GRID_POINTS_DEF   = 256;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int IDX_W             = 8;
    localparam int DATA_W            = 32;
    localparam int CFG_IDX_W         = 2;

    // Command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_INIT,
        OP_FWD,
        OP_BACK,
        OP_POST
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [12:0] j;
        logic        start;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_stat;

    // Saturate a 66-bit value to 32 bits.
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7fffffff};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h80000000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

[hw/rtl/tsps_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point divider
// Radix-2 restoring divider, one quotient bit a cycle, rounds half away from
// zero and saturates; a zero divisor returns zero and flags it.
// ----------------------------------------------------------------------------
module tsps_divider #(
    parameter int FRACTION_BITS = tsps_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic        o_sat,
    output logic        o_zero
);
    import tsps_pkg::*;

    localparam int NW = 32 + FRACTION_BITS + 1;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, n_num;
    logic [NW:0]   r_rem, n_rem;
    logic [33:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_neg;
    logic [NW:0]   w_trial;
    logic signed [65:0] w_sq;
    logic [32:0]   w_sat;

    // One shift and compare per cycle on (2|n|<<F + |d|) / (2|d|).
    always_comb begin
        w_trial = {r_rem[NW-1:0], r_num[NW-1]};
        n_num   = {r_num[NW-2:0], 1'b0};
        if (w_trial >= {{(NW-33){1'b0}}, r_den}) begin
            n_rem   = w_trial - {{(NW-33){1'b0}}, r_den};
            n_num[0] = 1'b1;
        end else begin
            n_rem = w_trial;
        end
    end

    assign w_sq  = r_neg ? -$signed(66'(r_num)) : $signed(66'(r_num));
    assign w_sat = sat32(w_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                logic [32:0] un, ud;
                un = i_num[31] ? 33'(-$signed({i_num[31], i_num})) : {1'b0, i_num};
                ud = i_den[31] ? 33'(-$signed({i_den[31], i_den})) : {1'b0, i_den};
                r_neg <= i_num[31] ^ i_den[31];
                r_num <= NW'({un, {FRACTION_BITS{1'b0}}, 1'b0}) + NW'(ud);
                r_den <= {ud, 1'b0};
                r_rem <= '0;
                r_cnt <= CW'(NW);
                o_zero <= (i_den == '0);
                r_busy <= (i_den != '0);
                if (i_den == '0) begin
                    o_quot <= '0;
                    o_sat  <= 1'b0;
                    o_done <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_quot <= w_sat[31:0];
                    o_sat  <= w_sat[32];
                end else begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
endmodule

[hw/rtl/tsps_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solver datapath
// Stores, one multiplier, one divider and the sweep arithmetic.
// ----------------------------------------------------------------------------
module tsps_datapath #(
    parameter int GRID_POINTS   = tsps_pkg::GRID_POINTS_DEF,
    parameter int FRACTION_BITS = tsps_pkg::FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsps_pkg::t_cmd        i_cmd,
    output tsps_pkg::t_stat       o_stat,
    input  logic [7:0]            i_idx,
    input  logic [31:0]           i_density,
    input  logic                  i_mode,
    input  logic [31:0]           i_scale,
    input  logic [31:0]           i_edge,
    input  logic [31:0]           i_inner,
    output logic [31:0]           o_potential,
    output logic [1:0]            o_status
);
    import tsps_pkg::*;

    localparam int AW = $clog2(GRID_POINTS);
    localparam logic [31:0] ONE = 32'(1) << FRACTION_BITS;
    localparam logic [31:0] TWO = 32'(2) << FRACTION_BITS;

    logic [31:0] r_dens [GRID_POINTS];
    logic [31:0] r_rat  [GRID_POINTS];
    logic [31:0] r_part [GRID_POINTS];
    logic [31:0] r_pot  [GRID_POINTS];
    // The first solve writes every potential, so one flag covers the store.
    logic        r_solved;

    logic [31:0] r_pivot, r_negp, r_negq, r_e, r_tmp, r_adj, r_next;
    logic        r_seen_sat, r_seen_zero;
    logic [1:0]  r_status;
    logic [3:0]  r_ph;
    logic        r_busy;
    logic [12:0] r_j;
    t_op         r_op;

    // Shared multiplier operands.
    logic [31:0] r_ma, r_mb;
    logic signed [63:0] w_prod;
    logic [32:0] w_mul;
    logic signed [65:0] w_rs;
    assign w_prod = $signed(r_ma) * $signed(r_mb);
    assign w_rs   = ($signed({{2{w_prod[63]}}, w_prod}) +
                     (66'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    assign w_mul  = sat32(w_rs);

    logic        r_dstart, w_ddone, w_dsat, w_dzero;
    logic [31:0] r_dn, r_dd, w_dq;
    tsps_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dn), .i_den(r_dd), .o_done(w_ddone), .o_quot(w_dq),
        .o_sat(w_dsat), .o_zero(w_dzero)
    );

    function automatic logic [32:0] sub32(input logic [31:0] a, input logic [31:0] b);
        return sat32(66'($signed(a)) - 66'($signed(b)));
    endfunction

    logic [AW-1:0] w_ja;
    assign w_ja = r_j[AW-1:0];
    logic [32:0] w_t, w_negp, w_negq;
    logic [31:0] w_sa, w_sb;
    logic        w_last, w_post_sat;

    // Negated diagonals, saturating.
    assign w_negp = sub32('0, i_edge);
    assign w_negq = sub32('0, i_inner);
    assign w_last = (r_j == 13'(GRID_POINTS - 1));

    // Operands of the shared saturating subtractor, picked by operation and phase.
    always_comb begin
        w_sa = r_tmp;
        w_sb = w_mul[31:0];
        if (r_op == OP_FWD) begin
            if (r_ph == 4'd2) begin
                w_sa = w_last ? r_negp : r_negq;
            end else begin
                w_sa = r_e;
            end
        end else if (r_op == OP_POST) begin
            if (i_mode == 1'b0) begin
                w_sa = '0;
                w_sb = r_tmp;
            end else begin
                w_sb = r_adj;
            end
        end
    end

    assign w_t = sub32(w_sa, w_sb);
    // A post-pass saturation only counts where a value is actually written.
    assign w_post_sat = w_t[32] && (i_mode || (r_j < 13'(GRID_POINTS / 2)));

    // Multi-phase sequence per grid point; the divider phases wait for the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_dstart <= 1'b0; r_solved <= 1'b0;
            r_status <= ST_OK; r_pivot <= '0; o_stat.done <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            o_stat.done <= 1'b0;
            if (i_cmd.start) begin
                r_op <= i_cmd.op; r_j <= i_cmd.j; r_ph <= '0;
                unique case (i_cmd.op)
                    OP_LOAD: begin
                        if (i_idx < GRID_POINTS) r_dens[AW'(i_idx)] <= i_density;
                        o_potential <= '0;
                        o_stat.done <= 1'b1;
                    end
                    OP_READ: begin
                        o_potential <= (i_idx < GRID_POINTS && r_solved)
                                       ? r_pot[AW'(i_idx)] : '0;
                        o_stat.done <= 1'b1;
                    end
                    OP_NONE: begin
                        o_potential <= '0;
                        o_stat.done <= 1'b1;
                    end
                    default: begin
                        o_potential <= '0;
                        r_busy <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                unique case (r_op)
                    OP_INIT: begin
                        // Negate p and q, then row zero.
                        unique case (r_ph)
                            4'd0: begin
                                r_seen_sat  <= w_negp[32] || w_negq[32];
                                r_seen_zero <= 1'b0;
                                r_negp <= w_negp[31:0];
                                r_negq <= w_negq[31:0];
                                r_ma <= r_dens[0]; r_mb <= i_scale; r_ph <= 4'd1;
                            end
                            4'd1: begin
                                r_seen_sat <= r_seen_sat | w_mul[32];
                                r_dn <= w_mul[31:0]; r_dd <= r_negp;
                                r_pivot <= r_negp; r_dstart <= 1'b1; r_ph <= 4'd2;
                            end
                            default: if (w_ddone) begin
                                r_seen_sat <= r_seen_sat | w_dsat;
                                r_seen_zero <= r_seen_zero | w_dzero;
                                r_part[0] <= w_dq;
                                r_busy <= 1'b0; o_stat.done <= 1'b1;
                            end
                        endcase
                    end
                    OP_FWD: begin
                        unique case (r_ph)
                            4'd0: begin
                                r_dn <= (r_j == 13'd1) ? TWO : ONE; r_dd <= r_pivot;
                                r_dstart <= 1'b1; r_ph <= 4'd1;
                            end
                            4'd1: if (w_ddone) begin
                                r_seen_sat <= r_seen_sat | w_dsat;
                                r_seen_zero <= r_seen_zero | w_dzero;
                                r_rat[w_ja - 1'b1] <= w_dq;
                                r_ma <= w_last ? TWO : ONE;
                                r_mb <= w_dq; r_ph <= 4'd2;
                            end
                            4'd2: begin
                                r_seen_sat <= r_seen_sat | w_mul[32] | w_t[32];
                                r_pivot <= w_t[31:0];
                                r_ma <= r_dens[w_ja]; r_mb <= i_scale; r_ph <= 4'd3;
                            end
                            4'd3: begin
                                r_seen_sat <= r_seen_sat | w_mul[32];
                                r_e <= w_mul[31:0];
                                r_ma <= w_last ? TWO : ONE;
                                r_mb <= r_part[w_ja - 1'b1]; r_ph <= 4'd4;
                            end
                            4'd4: begin
                                r_seen_sat <= r_seen_sat | w_mul[32] | w_t[32];
                                r_dn <= w_t[31:0]; r_dd <= r_pivot;
                                r_dstart <= 1'b1; r_ph <= 4'd5;
                            end
                            default: if (w_ddone) begin
                                r_seen_sat <= r_seen_sat | w_dsat;
                                r_seen_zero <= r_seen_zero | w_dzero;
                                r_part[w_ja] <= w_dq;
                                if (w_last) begin
                                    r_pot[w_ja] <= w_dq; r_next <= w_dq;
                                    r_solved <= 1'b1;
                                end
                                r_busy <= 1'b0; o_stat.done <= 1'b1;
                            end
                        endcase
                    end
                    OP_BACK: begin
                        unique case (r_ph)
                            4'd0: begin
                                r_ma <= r_rat[w_ja]; r_mb <= r_next;
                                r_tmp <= r_part[w_ja]; r_ph <= 4'd1;
                            end
                            default: begin
                                r_seen_sat <= r_seen_sat | w_mul[32] | w_t[32];
                                r_pot[w_ja] <= w_t[31:0]; r_next <= w_t[31:0];
                                if (w_ja == AW'(GRID_POINTS / 2)) r_adj <= w_t[31:0];
                                r_busy <= 1'b0; o_stat.done <= 1'b1;
                            end
                        endcase
                    end
                    default: begin
                        // Post pass; j counts up over the whole grid.
                        unique case (r_ph)
                            4'd0: begin
                                r_tmp <= r_pot[w_ja]; r_ph <= 4'd1;
                            end
                            4'd1: begin
                                r_seen_sat <= r_seen_sat | w_post_sat;
                                if (i_mode == 1'b0) begin
                                    if (r_j < 13'(GRID_POINTS / 2)) begin
                                        r_pot[AW'(GRID_POINTS - 1) - w_ja] <= w_t[31:0];
                                    end
                                end else begin
                                    r_pot[w_ja] <= w_t[31:0];
                                end
                                if (w_last) begin
                                    r_status <= r_seen_zero ? ST_ZERO :
                                                ((r_seen_sat | w_post_sat) ? ST_SAT : ST_OK);
                                end
                                r_busy <= 1'b0; o_stat.done <= 1'b1;
                            end
                            default: r_ph <= 4'd0;
                        endcase
                    end
                endcase
            end
        end
    end

    assign o_status = r_status;
endmodule

[hw/rtl/tsps_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solver controller
// Accepts command words, sequences the solve over the grid and holds the
// result word until it is taken.
// ----------------------------------------------------------------------------
module tsps_control #(
    parameter int GRID_POINTS = tsps_pkg::GRID_POINTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_code,
    output tsps_pkg::t_cmd   o_cmd,
    input  tsps_pkg::t_stat  i_stat,
    output logic             o_valid,
    input  logic             i_ready
);
    import tsps_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SIMPLE, S_INIT, S_FWD, S_BACK, S_POST, S_OUT}
        t_state;
    t_state      r_state;
    logic [12:0] r_j;

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; o_valid <= 1'b0; r_j <= '0;
            o_cmd <= '{op: OP_NONE, j: '0, start: 1'b0};
        end else begin
            o_cmd.start <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    o_cmd.start <= 1'b1; o_cmd.j <= '0;
                    unique case (i_code)
                        CMD_LOAD:  begin o_cmd.op <= OP_LOAD; r_state <= S_SIMPLE; end
                        CMD_READ:  begin o_cmd.op <= OP_READ; r_state <= S_SIMPLE; end
                        CMD_SOLVE: begin o_cmd.op <= OP_INIT; r_state <= S_INIT; end
                        default:   begin o_cmd.op <= OP_NONE; r_state <= S_SIMPLE; end
                    endcase
                end
                S_SIMPLE: if (i_stat.done) r_state <= S_OUT;
                S_INIT: if (i_stat.done) begin
                    r_j <= 13'd1; o_cmd.op <= OP_FWD; o_cmd.j <= 13'd1;
                    o_cmd.start <= 1'b1; r_state <= S_FWD;
                end
                S_FWD: if (i_stat.done) begin
                    if (r_j == 13'(GRID_POINTS - 1)) begin
                        o_cmd.op <= OP_BACK; o_cmd.j <= 13'(GRID_POINTS - 2);
                        r_j <= 13'(GRID_POINTS - 2); r_state <= S_BACK;
                    end else begin
                        o_cmd.j <= r_j + 1'b1; r_j <= r_j + 1'b1;
                    end
                    o_cmd.start <= 1'b1;
                end
                S_BACK: if (i_stat.done) begin
                    if (r_j == '0) begin
                        o_cmd.op <= OP_POST; r_state <= S_POST;
                        o_cmd.j <= '0;
                    end else begin
                        o_cmd.j <= r_j - 1'b1; r_j <= r_j - 1'b1;
                    end
                    o_cmd.start <= 1'b1;
                end
                S_POST: if (i_stat.done) begin
                    if (r_j == 13'(GRID_POINTS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        o_cmd.j <= r_j + 1'b1; r_j <= r_j + 1'b1;
                        o_cmd.start <= 1'b1;
                    end
                end
                default: begin
                    o_valid <= 1'b1; r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[hw/rtl/tridiagonal_screened_poisson_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal screened Poisson solver
// Thomas-algorithm line solver over a stored density grid, Q16.16.
// ----------------------------------------------------------------------------
// One command word at a time. A solve runs each grid point of the forward pass
// through a shared multiplier and a radix-2 divider, with two divisions a
// point, and then a back pass and a post pass over the grid. Status of the
// last solve is returned with every result word.
module tridiagonal_screened_poisson_solver #(
    parameter int GRID_POINTS   = tsps_pkg::GRID_POINTS_DEF,
    parameter int FRACTION_BITS = tsps_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd[1:0], grid_index[9:2], density[41:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // potential[31:0], status[33:32]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tsps_pkg::*;

    logic        r_mode;
    logic [31:0] r_scale, r_edge, r_inner;
    logic [7:0]  r_idx;
    logic [31:0] r_dens, w_pot;
    logic [1:0]  w_status;
    t_cmd        w_cmd;
    t_stat       w_stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_scale <= 32'h00010000;
            r_edge <= 32'h00020000; r_inner <= 32'h00020000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[0];
                REG_SCALE: r_scale <= i_cfg_data;
                REG_EDGE:  r_edge  <= i_cfg_data;
                default:   r_inner <= i_cfg_data;
            endcase
        end
    end

    // Capture operand fields on acceptance.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_idx  <= s_axis_tdata[9:2];
            r_dens <= s_axis_tdata[41:10];
        end
    end

    tsps_control #(.GRID_POINTS(GRID_POINTS)) u_ctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_code(s_axis_tdata[1:0]), .o_cmd(w_cmd),
        .i_stat(w_stat), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready)
    );

    tsps_datapath #(.GRID_POINTS(GRID_POINTS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_idx(r_idx), .i_density(r_dens), .i_mode(r_mode), .i_scale(r_scale),
        .i_edge(r_edge), .i_inner(r_inner), .o_potential(w_pot), .o_status(w_status)
    );

    assign m_axis_tdata = {6'd0, w_status, w_pot};
endmodule

[hw/rtl/tsps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solver port checker
// Watches the stream ports of the solver over time.
// ----------------------------------------------------------------------------
module tsps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // A result word holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // No new word is taken while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");

    // Status is never the unused code.
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
        else $error("bad status");

    // An accepted word is followed by a busy cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after accept");
endmodule

bind tridiagonal_screened_poisson_solver tsps_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
